// File: design/u8dec_pkg.sv
`default_nettype none

package u8dec_pkg;

   localparam int BYTE_W = 8;
   localparam int CP_W   = 31;
   localparam int EXP_W  = 3;

   // default depth of the queue between decoder and emitter
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [CP_W-1:0] REPLACEMENT_CP = CP_W'(32'h0000_FFFD);

   // one decoded request outcome: a single result, or a replacement followed by one
   typedef struct packed {
      logic            pair;
      logic            repl;
      logic [CP_W-1:0] cp;
   } dec_entry_type;

endpackage

`default_nettype wire

// File: design/utf8_byte_stream_decoder.sv
// path: a request byte's results pass through the decode queue, then the output register
// throughput: one request byte per cycle while the queue is not full; a byte that ends an
// interrupted sequence and also stands for itself gives two results, sent one after the other
// the decode queue absorbs such bursts; intake keeps one byte per cycle until it is full
// reset: synchronous, active high; clears the open sequence, the queue and the output
`default_nettype none

module utf8_byte_stream_decoder
   import u8dec_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel: raw bytes
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] byte_in
   // result channel: decoded code points
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [30:0] code_point, [31] zero
   output logic             rsp_tuser,   // [0] replaced
   output logic             rsp_tlast    // last result caused by one request byte
);

   // front to queue
   logic          q_push;
   logic          q_full;
   dec_entry_type q_entry;

   // queue to back
   logic          q_pop;
   logic          q_not_empty;
   dec_entry_type q_head;

   logic [CP_W-1:0] rsp_cp;

   // front: takes bytes, tracks the open sequence, decides which results a byte makes
   u8dec_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_byte  (req_tdata),
      .req_ready (req_tready),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_entry)
   );

   // short queue so the decoder keeps going while the output stalls
   u8dec_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   // back: splits a pair into two results and drives the output register
   u8dec_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_cp      (rsp_cp),
      .rsp_repl    (rsp_tuser),
      .rsp_last    (rsp_tlast)
   );

   // code point in the low bits, padded to a whole number of bytes
   assign rsp_tdata = {1'b0, rsp_cp};

endmodule

`default_nettype wire

// File: design/u8dec_front.sv
`default_nettype none

module u8dec_front
   import u8dec_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [BYTE_W-1:0] req_byte,
   output logic                   req_ready,
   input  wire logic              q_full,
   output logic                   q_push,
   output dec_entry_type          q_entry
);

   logic [EXP_W-1:0] exp_ff, exp_in;
   logic [CP_W-1:0]  acc_ff, acc_in;
   logic             accept;
   logic             is_cont;

   // handling of a byte with no sequence open
   logic             fr_emit;
   logic             fr_repl;
   logic [CP_W-1:0]  fr_cp;
   logic [EXP_W-1:0] fr_exp;
   logic [CP_W-1:0]  fr_acc;

   logic             emit;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign is_cont   = (req_byte[7:6] == 2'b10);

   always_comb begin
      fr_emit = 1'b0;
      fr_repl = 1'b0;
      fr_cp   = {{(CP_W-BYTE_W){1'b0}}, req_byte};
      fr_exp  = '0;
      fr_acc  = '0;
      priority if (!req_byte[7]) begin
         fr_emit = 1'b1;
      end else if (req_byte[7:1] == 7'h7F) begin
         fr_emit = 1'b1;
         fr_repl = 1'b1;
         fr_cp   = REPLACEMENT_CP;
      end else if (!req_byte[5]) begin
         fr_exp = EXP_W'(1);
         fr_acc = {{(CP_W-5){1'b0}}, req_byte[4:0]};
      end else if (!req_byte[4]) begin
         fr_exp = EXP_W'(2);
         fr_acc = {{(CP_W-4){1'b0}}, req_byte[3:0]};
      end else if (!req_byte[3]) begin
         fr_exp = EXP_W'(3);
         fr_acc = {{(CP_W-3){1'b0}}, req_byte[2:0]};
      end else if (!req_byte[2]) begin
         fr_exp = EXP_W'(4);
         fr_acc = {{(CP_W-2){1'b0}}, req_byte[1:0]};
      end else begin
         fr_exp = EXP_W'(5);
         fr_acc = {{(CP_W-1){1'b0}}, req_byte[0]};
      end
   end

   always_comb begin
      exp_in  = exp_ff;
      acc_in  = acc_ff;
      emit    = 1'b0;
      q_entry = '0;
      if (exp_ff != '0) begin
         if (is_cont) begin
            acc_in = {acc_ff[CP_W-7:0], req_byte[5:0]};
            exp_in = exp_ff - EXP_W'(1);
            if (exp_ff == EXP_W'(1)) begin
               emit       = 1'b1;
               q_entry.cp = acc_in;
            end
         end else begin
            // interrupted sequence: replacement first, then the byte afresh
            emit   = 1'b1;
            exp_in = fr_exp;
            acc_in = fr_acc;
            if (fr_emit) begin
               q_entry.pair = 1'b1;
               q_entry.cp   = fr_cp;
               q_entry.repl = fr_repl;
            end else begin
               q_entry.cp   = REPLACEMENT_CP;
               q_entry.repl = 1'b1;
            end
         end
      end else if (!is_cont) begin
         exp_in       = fr_exp;
         acc_in       = fr_acc;
         emit         = fr_emit;
         q_entry.cp   = fr_cp;
         q_entry.repl = fr_repl;
      end
   end

   assign q_push = accept && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff <= '0;
         acc_ff <= '0;
      end else if (accept) begin
         exp_ff <= exp_in;
         acc_ff <= acc_in;
      end
   end

endmodule

`default_nettype wire

// File: design/u8dec_queue.sv
`default_nettype none

module u8dec_queue
   import u8dec_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire dec_entry_type push_entry,
   output logic               full,
   input  wire logic          pop,
   output logic               not_empty,
   output dec_entry_type      head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   dec_entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             do_push, do_pop;

   assign full      = (cnt_ff == CNT_W'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ptr_next(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= ptr_next(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

// File: design/u8dec_back.sv
`default_nettype none

module u8dec_back
   import u8dec_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_not_empty,
   input  wire dec_entry_type q_head,
   output logic               q_pop,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [CP_W-1:0]    rsp_cp,
   output logic               rsp_repl,
   output logic               rsp_last
);

   logic            valid_ff, valid_in;
   logic [CP_W-1:0] cp_ff, cp_in;
   logic            repl_ff, repl_in;
   logic            last_ff, last_in;
   // second result of a pair, waiting behind the replacement
   logic            pend_ff, pend_in;
   logic [CP_W-1:0] pend_cp_ff, pend_cp_in;
   logic            pend_repl_ff, pend_repl_in;
   logic            load;

   assign load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in     = valid_ff;
      cp_in        = cp_ff;
      repl_in      = repl_ff;
      last_in      = last_ff;
      pend_in      = pend_ff;
      pend_cp_in   = pend_cp_ff;
      pend_repl_in = pend_repl_ff;
      q_pop        = 1'b0;
      if (load) begin
         priority if (pend_ff) begin
            valid_in = 1'b1;
            cp_in    = pend_cp_ff;
            repl_in  = pend_repl_ff;
            last_in  = 1'b1;
            pend_in  = 1'b0;
         end else if (q_not_empty) begin
            q_pop    = 1'b1;
            valid_in = 1'b1;
            if (q_head.pair) begin
               cp_in        = REPLACEMENT_CP;
               repl_in      = 1'b1;
               last_in      = 1'b0;
               pend_in      = 1'b1;
               pend_cp_in   = q_head.cp;
               pend_repl_in = q_head.repl;
            end else begin
               cp_in   = q_head.cp;
               repl_in = q_head.repl;
               last_in = 1'b1;
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cp_ff        <= cp_in;
      repl_ff      <= repl_in;
      last_ff      <= last_in;
      pend_cp_ff   <= pend_cp_in;
      pend_repl_ff <= pend_repl_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_cp    = cp_ff;
   assign rsp_repl  = repl_ff;
   assign rsp_last  = last_ff;

endmodule

`default_nettype wire

// File: design/u8dec_checker.sv
`default_nettype none

module u8dec_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        rsp_tlast
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // a replacement always carries U+FFFD
   a_repl_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 32'h0000_FFFD)
      else $error("replacement flag without U+FFFD");

   // only the leading replacement of a pair is not last
   a_first_is_repl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser)
      else $error("non-final result that is not a replacement");

   // the second result of a pair follows right away
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && rsp_tlast)
      else $error("second result of a pair missing");

   // code points stay within 31 bits
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[31])
      else $error("padding bit set");

endmodule

bind utf8_byte_stream_decoder u8dec_checker u_checker (.*);

`default_nettype wire
